// File: src/lzwv_pkg.sv
// ----------------------------------------------------------------------------
// lzwv_pkg
// Shared constants, types and the slot hash of the variable width LZW encoder.
// ----------------------------------------------------------------------------
package lzwv_pkg;

    localparam int DICT_BITS  = 12;
    localparam int HASH_SLOTS = 4096;
    localparam int SLOT_BITS  = $clog2(HASH_SLOTS);
    localparam int KEY_W      = DICT_BITS + 8;
    localparam int CODE_W     = DICT_BITS;
    localparam int NC_W       = DICT_BITS + 1;
    localparam int WID_W      = 5;
    localparam int HASH_W     = SLOT_BITS + 7;
    localparam int ENTRY_W    = 1 + KEY_W + CODE_W;
    localparam int ACC_W      = DICT_BITS + 7;
    localparam int CNT_W      = $clog2(ACC_W + 1);
    localparam int FIRST_CODE = 256;
    localparam int INIT_WIDTH = 8;
    localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

    typedef logic [WID_W-1:0]     width_t;
    typedef logic [CODE_W-1:0]    code_t;
    typedef logic [KEY_W-1:0]     key_t;
    typedef logic [SLOT_BITS-1:0] slot_t;

    typedef struct packed {
        logic   valid;
        code_t  code;
        width_t width;
        logic   flush;
    } push_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_CHECK,
        ST_MISS,
        ST_FINAL
    } state_t;

    function automatic slot_t slot_of(input key_t key);
        logic [HASH_W-1:0] prod;
        prod = HASH_W'(key) * HASH_MULT[HASH_W-1:0];
        return prod[HASH_W-1:7];
    endfunction

endpackage

// File: src/lzwv_dict_ram.sv
// ----------------------------------------------------------------------------
// lzwv_dict_ram
// Single port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module lzwv_dict_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 33
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: src/lzwv_packer.sv
// ----------------------------------------------------------------------------
// lzwv_packer
// Packs codes MSB first into bytes, pads the final byte, holds the output item.
// ----------------------------------------------------------------------------
module lzwv_packer (
    input  logic          aclk,
    input  logic          aresetn,
    input  lzwv_pkg::push_t push,
    output logic          push_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_out_byte,
    output logic [2:0]    m_pad_bits,
    output logic          m_end_of_stream
);
    import lzwv_pkg::*;

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             flush_reg, flush_next;
    logic             ov_reg, ov_next;
    logic [7:0]       byte_reg, byte_next;
    logic [2:0]       pad_reg, pad_next;
    logic             eos_reg, eos_next;

    logic             can_load;
    logic [CNT_W-1:0] cnt_less;
    logic [ACC_W-1:0] code_mask;

    assign push_ready = (cnt_reg < CNT_W'(8)) && !flush_reg;
    assign can_load   = !ov_reg || m_ready;
    assign cnt_less   = cnt_reg - CNT_W'(8);
    assign code_mask  = (ACC_W'(1) << push.width) - ACC_W'(1);

    always_comb begin
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        flush_next = flush_reg;
        ov_next    = ov_reg && !m_ready;
        byte_next  = byte_reg;
        pad_next   = pad_reg;
        eos_next   = eos_reg;
        if (push.valid && push_ready) begin
            acc_next   = (acc_reg << push.width) | (ACC_W'(push.code) & code_mask);
            cnt_next   = cnt_reg + CNT_W'(push.width);
            flush_next = push.flush;
        end else if (cnt_reg >= CNT_W'(8) && can_load) begin
            ov_next    = 1'b1;
            byte_next  = 8'(acc_reg >> cnt_less);
            pad_next   = 3'd0;
            eos_next   = flush_reg && (cnt_less == '0);
            cnt_next   = cnt_less;
            acc_next   = acc_reg & ((ACC_W'(1) << cnt_less) - ACC_W'(1));
            if (flush_reg && (cnt_less == '0)) begin
                flush_next = 1'b0;
            end
        end else if (flush_reg && cnt_reg != '0 && can_load) begin
            ov_next    = 1'b1;
            byte_next  = 8'(acc_reg << (CNT_W'(8) - cnt_reg));
            pad_next   = 3'(CNT_W'(8) - cnt_reg);
            eos_next   = 1'b1;
            cnt_next   = '0;
            acc_next   = '0;
            flush_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            cnt_reg   <= '0;
            flush_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            flush_reg <= flush_next;
            ov_reg    <= ov_next;
        end
        byte_reg <= byte_next;
        pad_reg  <= pad_next;
        eos_reg  <= eos_next;
    end

    assign m_valid         = ov_reg;
    assign m_out_byte      = byte_reg;
    assign m_pad_bits      = pad_reg;
    assign m_end_of_stream = eos_reg;

endmodule

// File: src/lzw_variable_width_encoder.sv
// ----------------------------------------------------------------------------
// lzw_variable_width_encoder
// LZW byte encoder over a hashed dictionary RAM with growing code width.
// ----------------------------------------------------------------------------
// a dictionary hit runs ST_HASH, ST_PROBE and ST_CHECK, and each extra probe
// step repeats ST_PROBE and ST_CHECK; a miss adds ST_MISS to push the code,
// then bytes leave the packer one per cycle while m_ready is held high; the
// first byte of a stream needs no lookup, later bytes wait for ST_IDLE; after
// reset and each end of stream all 4096 HASH_SLOTS are cleared before input
module lzw_variable_width_encoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_is_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [2:0] m_pad_bits,
    output logic       m_end_of_stream
);
    import lzwv_pkg::*;

    state_t           state_reg, state_next;
    code_t            match_reg, match_next;
    logic             active_reg, active_next;
    logic [NC_W-1:0]  nc_reg, nc_next;
    width_t           width_reg, width_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    key_t             key_reg, key_next;
    slot_t            slot_reg, slot_next;
    logic [SLOT_BITS:0] probe_reg, probe_next;
    logic             slot_ok_reg, slot_ok_next;
    slot_t            clr_reg, clr_next;

    logic               ram_we;
    slot_t              ram_addr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic               e_valid;
    key_t               e_key;
    code_t              e_code;
    push_t              push;
    logic               push_ready;
    logic               accept;
    logic               can_insert;
    logic [NC_W-1:0]    nc_inc;

    assign {e_valid, e_key, e_code} = ram_rdata;
    assign accept = s_valid && s_ready;
    assign nc_inc = nc_reg + NC_W'(1);
    assign can_insert = slot_ok_reg && !nc_reg[DICT_BITS]
        && ((32'(nc_reg) - 32'(FIRST_CODE)) < 32'(HASH_SLOTS));

    lzwv_dict_ram #(
        .DEPTH(HASH_SLOTS),
        .WIDTH(ENTRY_W)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    lzwv_packer u_packer (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .push           (push),
        .push_ready     (push_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_pad_bits     (m_pad_bits),
        .m_end_of_stream(m_end_of_stream)
    );

    // next state
    always_comb begin
        state_next   = state_reg;
        match_next   = match_reg;
        active_next  = active_reg;
        nc_next      = nc_reg;
        width_next   = width_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;
        key_next     = key_reg;
        slot_next    = slot_reg;
        probe_next   = probe_reg;
        slot_ok_next = slot_ok_reg;
        clr_next     = clr_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + SLOT_BITS'(1);
                if (clr_reg == SLOT_BITS'(HASH_SLOTS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    byte_next = s_in_byte;
                    last_next = s_is_last;
                    key_next  = {match_reg, s_in_byte};
                    if (!active_reg) begin
                        match_next  = code_t'(s_in_byte);
                        active_next = 1'b1;
                        if (s_is_last) begin
                            state_next = ST_FINAL;
                        end
                    end else begin
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH: begin
                slot_next  = slot_of(key_reg);
                probe_next = '0;
                state_next = ST_PROBE;
            end
            ST_PROBE: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (!e_valid) begin
                    slot_ok_next = 1'b1;
                    state_next   = ST_MISS;
                end else if (e_key == key_reg) begin
                    match_next = e_code;
                    state_next = last_reg ? ST_FINAL : ST_IDLE;
                end else if (probe_reg == (SLOT_BITS + 1)'(HASH_SLOTS - 1)) begin
                    slot_ok_next = 1'b0;
                    state_next   = ST_MISS;
                end else begin
                    slot_next  = slot_reg + SLOT_BITS'(1);
                    probe_next = probe_reg + (SLOT_BITS + 1)'(1);
                    state_next = ST_PROBE;
                end
            end
            ST_MISS: begin
                if (push_ready) begin
                    if (can_insert) begin
                        nc_next = nc_inc;
                        if ((32'(width_reg) < 32'(DICT_BITS))
                            && ((32'(nc_inc) >> width_reg) != 32'd0)) begin
                            width_next = width_reg + WID_W'(1);
                        end
                    end
                    match_next = code_t'(byte_reg);
                    state_next = last_reg ? ST_FINAL : ST_IDLE;
                end
            end
            ST_FINAL: begin
                if (push_ready) begin
                    match_next  = '0;
                    active_next = 1'b0;
                    nc_next     = NC_W'(FIRST_CODE);
                    width_next  = WID_W'(INIT_WIDTH);
                    clr_next    = '0;
                    state_next  = ST_CLEAR;
                end
            end
            default: begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_ready    = (state_reg == ST_IDLE);
        ram_we     = 1'b0;
        ram_addr   = slot_reg;
        ram_wdata  = {1'b1, key_reg, nc_reg[CODE_W-1:0]};
        push.valid = 1'b0;
        push.code  = match_reg;
        push.width = width_reg;
        push.flush = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = '0;
            end
            ST_MISS: begin
                push.valid = 1'b1;
                ram_we     = push_ready && can_insert;
            end
            ST_FINAL: begin
                push.valid = 1'b1;
                push.flush = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            match_reg   <= '0;
            active_reg  <= 1'b0;
            nc_reg      <= NC_W'(FIRST_CODE);
            width_reg   <= WID_W'(INIT_WIDTH);
            clr_reg     <= '0;
            probe_reg   <= '0;
            slot_ok_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            match_reg   <= match_next;
            active_reg  <= active_next;
            nc_reg      <= nc_next;
            width_reg   <= width_next;
            clr_reg     <= clr_next;
            probe_reg   <= probe_next;
            slot_ok_reg <= slot_ok_next;
        end
        byte_reg <= byte_next;
        last_reg <= last_next;
        key_reg  <= key_next;
        slot_reg <= slot_next;
    end

endmodule
